// ----- rtl/ictq_pkg.sv -----
// ----------------------------------------------------------------------------
// ictq_pkg
// Shared widths, operation codes and timer arithmetic for the idle timer list.
// ----------------------------------------------------------------------------
package ictq_pkg;

	localparam int OP_W   = 2;
	localparam int TIME_W = 32;
	localparam int NEXT_W = TIME_W + 1;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_SCAN   = 2'd2;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;
	localparam logic [NEXT_W-1:0] NEXT_EMPTY    = {NEXT_W{1'b1}};

	// elapsed time strictly beyond the timeout
	function automatic logic is_expired(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] start, input logic [TIME_W-1:0] timeout);
		logic [TIME_W-1:0] elapsed;
		elapsed = now - start;
		return elapsed > timeout;
	endfunction

	// time left until expiry, zero once due
	function automatic logic [NEXT_W-1:0] time_left(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] start, input logic [TIME_W-1:0] timeout);
		logic [TIME_W-1:0] elapsed;
		elapsed = now - start;
		if (elapsed >= timeout) begin
			return '0;
		end
		return {1'b0, timeout - elapsed};
	endfunction

endpackage

// ----- rtl/ictq_if.sv -----
// ----------------------------------------------------------------------------
// ictq_if
// Valid/ready channels: request words in, result words out.
// ----------------------------------------------------------------------------
interface ictq_in_if
	import ictq_pkg::*;
#(
	parameter int ID_BITS = 10
) ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [ID_BITS-1:0] conn_id;
	logic [TIME_W-1:0]  now_ms;

	modport source (output valid, operation, conn_id, now_ms, input ready);
	modport sink   (input valid, operation, conn_id, now_ms, output ready);
endinterface

interface ictq_out_if
	import ictq_pkg::*;
#(
	parameter int ID_BITS = 10
) ();
	logic                     valid;
	logic                     ready;
	logic                     status;
	logic                     expired_valid;
	logic [ID_BITS-1:0]       expired_id;
	logic signed [NEXT_W-1:0] next_timeout_ms;
	logic                     last;

	modport source (output valid, status, expired_valid, expired_id, next_timeout_ms, last,
		input ready);
	modport sink   (input valid, status, expired_valid, expired_id, next_timeout_ms, last,
		output ready);
endinterface

// ----- rtl/ictq_ram.sv -----
// ----------------------------------------------------------------------------
// ictq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ictq_ram #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/idle_connection_timeout_queue_top.sv -----
// ----------------------------------------------------------------------------
// idle_connection_timeout_queue_top
// Ordered list of idle timers, oldest first, kept as a ring in one RAM.
//
// channel   dir  handshake      payload
// items     in   valid/ready    operation, conn_id, now_ms
// results   out  valid/ready    status, expired_valid, expired_id,
//                               next_timeout_ms, last
// cfg       in   cfg_we         cfg_wdata -> timeout_ms
//
// Add/remove walk the whole list through the RAM read port, one entry per
// cycle. A scan walks the expired head entries, one per cycle, then reads
// each popped id back from the RAM to build its result.
// Reset empties the list at once; RAM contents are not cleared.
// A stalled result is held in the output register; the next word is taken
// once the last result of the current one is loaded there.
// ----------------------------------------------------------------------------
module idle_connection_timeout_queue_top
	import ictq_pkg::*;
#(
	parameter int LIST_DEPTH = 64,
	parameter int ID_BITS    = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TIME_W-1:0] cfg_wdata,
	ictq_in_if.sink           items,
	ictq_out_if.source        results
);

	localparam int PW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int MW = ID_BITS + TIME_W;
	localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_APPEND,
		ST_FRONT_RD,
		ST_FRONT_DATA,
		ST_SCAN,
		ST_SCAN_END,
		ST_EMIT_RD,
		ST_EMIT_DATA
	} state_t;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	state_t             state_q;
	logic [TIME_W-1:0]  timeout_q;
	logic [PW-1:0]      head_q, tail_q;
	logic [CW-1:0]      count_q;

	logic [OP_W-1:0]    op_q;
	logic [ID_BITS-1:0] id_q;
	logic [TIME_W-1:0]  now_q;

	logic [PW-1:0]      rp_q, hole_q, pop_q, ep_q;
	logic [CW-1:0]      rd_left_q, n_q, emit_left_q;
	logic               found_q;
	logic               refused_q;
	logic               v_s1;
	logic [PW-1:0]      a_s1;
	logic [NEXT_W-1:0]  next_q;

	logic                     out_valid_q;
	logic                     out_status_q;
	logic                     out_xv_q;
	logic [ID_BITS-1:0]       out_id_q;
	logic [NEXT_W-1:0]        out_next_q;
	logic                     out_last_q;
	logic                     out_free;

	logic               mem_we, mem_re;
	logic [PW-1:0]      mem_waddr, mem_raddr;
	logic [MW-1:0]      mem_wdata, mem_rdata;
	logic [ID_BITS-1:0] rd_id;
	logic [TIME_W-1:0]  rd_time;

	assign rd_id    = mem_rdata[MW-1:TIME_W];
	assign rd_time  = mem_rdata[TIME_W-1:0];
	assign out_free = !out_valid_q || results.ready;

	ictq_ram #(
		.WIDTH (MW),
		.DEPTH (LIST_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = hole_q;
		mem_raddr = rp_q;
		mem_wdata = mem_rdata;
		unique case (state_q)
			ST_WALK: begin
				mem_re = (rd_left_q != '0);
				mem_we = v_s1 && found_q;
			end
			ST_APPEND: begin
				mem_we    = (count_q < FULL);
				mem_waddr = tail_q;
				mem_wdata = {id_q, now_q};
			end
			ST_SCAN: begin
				mem_re = (rd_left_q != '0);
			end
			ST_FRONT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = head_q;
			end
			ST_EMIT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = ep_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			timeout_q   <= TIMEOUT_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= 1'b0;

			if (state_q == ST_WALK || state_q == ST_SCAN) begin
				if (rd_left_q != '0) begin
					rp_q      <= ptr_inc(rp_q);
					rd_left_q <= rd_left_q - 1'b1;
					v_s1      <= 1'b1;
					a_s1      <= rp_q;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (items.valid) begin
						op_q      <= items.operation;
						id_q      <= items.conn_id;
						now_q     <= items.now_ms;
						rp_q      <= head_q;
						pop_q     <= head_q;
						rd_left_q <= count_q;
						found_q   <= 1'b0;
						n_q       <= '0;
						refused_q <= 1'b0;
						if (items.operation == OP_ADD || items.operation == OP_REMOVE) begin
							state_q <= ST_WALK;
						end else if (items.operation == OP_SCAN) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FRONT_RD;
						end
					end
				end
				ST_WALK: begin
					if (v_s1) begin
						if (found_q) begin
							hole_q <= a_s1;
						end else if (rd_id == id_q) begin
							found_q <= 1'b1;
							hole_q  <= a_s1;
						end
					end else if (rd_left_q == '0) begin
						if (found_q) begin
							count_q <= count_q - 1'b1;
							tail_q  <= hole_q;
						end
						state_q <= (op_q == OP_ADD) ? ST_APPEND : ST_FRONT_RD;
					end
				end
				ST_APPEND: begin
					if (count_q < FULL) begin
						tail_q  <= ptr_inc(tail_q);
						count_q <= count_q + 1'b1;
					end else begin
						refused_q <= 1'b1;
					end
					state_q <= ST_FRONT_RD;
				end
				ST_FRONT_RD: begin
					state_q <= ST_FRONT_DATA;
				end
				ST_FRONT_DATA: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= refused_q;
						out_xv_q     <= 1'b0;
						out_id_q     <= '0;
						out_last_q   <= 1'b1;
						out_next_q   <= (count_q == '0) ? NEXT_EMPTY :
							time_left(now_q, rd_time, timeout_q);
						state_q      <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (v_s1) begin
						if (is_expired(now_q, rd_time, timeout_q)) begin
							n_q   <= n_q + 1'b1;
							pop_q <= ptr_inc(pop_q);
						end else begin
							next_q  <= time_left(now_q, rd_time, timeout_q);
							state_q <= ST_SCAN_END;
						end
					end else if (rd_left_q == '0) begin
						next_q  <= NEXT_EMPTY;
						state_q <= ST_SCAN_END;
					end
				end
				ST_SCAN_END: begin
					head_q      <= pop_q;
					count_q     <= count_q - n_q;
					ep_q        <= head_q;
					emit_left_q <= n_q;
					if (n_q != '0) begin
						state_q <= ST_EMIT_RD;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= 1'b0;
						out_xv_q     <= 1'b0;
						out_id_q     <= '0;
						out_last_q   <= 1'b1;
						out_next_q   <= next_q;
						state_q      <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					ep_q        <= ptr_inc(ep_q);
					emit_left_q <= emit_left_q - 1'b1;
					state_q     <= ST_EMIT_DATA;
				end
				ST_EMIT_DATA: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= 1'b0;
						out_xv_q     <= 1'b1;
						out_id_q     <= rd_id;
						out_last_q   <= (emit_left_q == '0);
						out_next_q   <= next_q;
						state_q      <= (emit_left_q == '0) ? ST_IDLE : ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign items.ready             = (state_q == ST_IDLE);
	assign results.valid           = out_valid_q;
	assign results.status          = out_status_q;
	assign results.expired_valid   = out_xv_q;
	assign results.expired_id      = out_id_q;
	assign results.next_timeout_ms = out_next_q;
	assign results.last            = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("list count beyond depth");

	a_ring_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == FULL) |-> head_q == tail_q)
		else $error("ring pointers disagree with count");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SCAN_END || state_q == ST_EMIT_RD ||
		 state_q == ST_EMIT_DATA) |-> !mem_we)
		else $error("RAM written during scan");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready) |=> !items.ready)
		else $error("second word taken while busy");

	a_expired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.status) |-> (!results.expired_valid && results.last))
		else $error("refused add carries expired entry");

endmodule
